@@ rtl/sfdl_pkg.sv @@
// ----------------------------------------------------------------------------
// sfdl_pkg
// Shared codes, widths and reset values for the supply fault debounce and
// warning lamp block.
// ----------------------------------------------------------------------------
package sfdl_pkg;

    localparam int FAULT_W    = 32;
    localparam int VOLT_W     = 12;
    localparam int RPM_W      = 16;
    localparam int TICK_W     = 16;
    localparam int BITPOS_W   = 5;
    localparam int DEB_W      = 10;
    localparam int STROKE_W   = 8;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DEBOUNCE_CHECKS_DEF = 800;
    localparam int FAULT_BITS_DEF      = 32;

    typedef logic [ACTION_W-1:0]  action_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam action_t ACT_CHECK  = 2'd0;
    localparam action_t ACT_TICK   = 2'd1;
    localparam action_t ACT_STROKE = 2'd2;
    localparam action_t ACT_CLEAR  = 2'd3;

    localparam cfg_idx_t REG_SUPPLY_MIN   = 3'd0;
    localparam cfg_idx_t REG_SUPPLY_MAX   = 3'd1;
    localparam cfg_idx_t REG_SUPPLY_FLOOR = 3'd2;
    localparam cfg_idx_t REG_RPM_THRESH   = 3'd3;
    localparam cfg_idx_t REG_LAMP_HOLD    = 3'd4;
    localparam cfg_idx_t REG_LOW_PRIO     = 3'd5;
    localparam cfg_idx_t REG_UNSAVED      = 3'd6;
    localparam cfg_idx_t REG_SUPPLY_BIT   = 3'd7;

    localparam logic [VOLT_W-1:0]   SUPPLY_MIN_RST   = 12'd0;
    localparam logic [VOLT_W-1:0]   SUPPLY_MAX_RST   = 12'd4095;
    localparam logic [VOLT_W-1:0]   SUPPLY_FLOOR_RST = 12'd1600;
    localparam logic [RPM_W-1:0]    RPM_THRESH_RST   = 16'd2500;
    localparam logic [TICK_W-1:0]   LAMP_HOLD_RST    = 16'd50;
    localparam logic [FAULT_W-1:0]  LOW_PRIO_RST     = 32'd0;
    localparam logic [FAULT_W-1:0]  UNSAVED_RST      = 32'd1;
    localparam logic [BITPOS_W-1:0] SUPPLY_BIT_RST   = 5'd0;

    localparam logic [STROKE_W-1:0] LOW_PRIO_STROKE = 8'd254;
    localparam logic [STROKE_W-1:0] STROKE_MAX      = 8'd255;

endpackage

@@ rtl/supply_fault_debounce_and_warning_lamp.sv @@
// ----------------------------------------------------------------------------
// supply_fault_debounce_and_warning_lamp
// Fault vector keeper with debounced supply check and warning lamp timer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall), one request per cycle unless stalled:
//   check, tick, stroke or clear, with voltage, rpm and external set/clear masks.
//   Output channel (out_valid/out_stall) returns one result per request:
//   fault vector, merged fault record, lamp drive and save request.
//   Config registers are written through cfg_write/cfg_index/cfg_data; the user
//   must do so only while the block is idle, which the block does not enforce.
// Registering:
//   State registers load at the accepting edge; the result goes to the output
//   register if it is free, offered from the next cycle, else to the skid
//   register. One request per cycle unless stalled, set by the combinational
//   compare/update path into the state and result registers.
// Stall:
//   A result waiting under out_stall does not block input; one more request
//   lands in a skid register, and in_stall rises only while that is full.
// Reset:
//   Config returns to defaults, faults and record clear, lamp lit with the
//   hold timer loaded, no result pending.
// ----------------------------------------------------------------------------
module supply_fault_debounce_and_warning_lamp #(
    parameter int DEBOUNCE_CHECKS = sfdl_pkg::DEBOUNCE_CHECKS_DEF,
    parameter int FAULT_BITS      = sfdl_pkg::FAULT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [sfdl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfdl_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sfdl_pkg::ACTION_W-1:0]       action,
    input  logic [sfdl_pkg::VOLT_W-1:0]         supply_voltage,
    input  logic [sfdl_pkg::RPM_W-1:0]          engine_rpm,
    input  logic [sfdl_pkg::FAULT_W-1:0]        fault_set,
    input  logic [sfdl_pkg::FAULT_W-1:0]        fault_clear,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sfdl_pkg::FAULT_W-1:0]        fault_vector,
    output logic [sfdl_pkg::FAULT_W-1:0]        merged_faults,
    output logic                                lamp_lit,
    output logic                                save_request
);

    localparam logic [63:0] MASK64 = (FAULT_BITS >= 64) ? {64{1'b1}}
                                   : ((64'd1 << FAULT_BITS) - 64'd1);
    localparam logic [sfdl_pkg::FAULT_W-1:0] VEC_MASK = MASK64[sfdl_pkg::FAULT_W-1:0];
    localparam logic [sfdl_pkg::DEB_W-1:0]   DEB_LOAD = sfdl_pkg::DEB_W'(DEBOUNCE_CHECKS);

    typedef struct packed {
        logic [sfdl_pkg::FAULT_W-1:0] faults;
        logic [sfdl_pkg::FAULT_W-1:0] merged;
        logic                         lamp;
        logic                         save;
    } result_t;

    // config
    logic [sfdl_pkg::VOLT_W-1:0]   supply_min_reg;
    logic [sfdl_pkg::VOLT_W-1:0]   supply_max_reg;
    logic [sfdl_pkg::VOLT_W-1:0]   supply_floor_reg;
    logic [sfdl_pkg::RPM_W-1:0]    rpm_thresh_reg;
    logic [sfdl_pkg::TICK_W-1:0]   lamp_hold_reg;
    logic [sfdl_pkg::FAULT_W-1:0]  low_prio_reg;
    logic [sfdl_pkg::FAULT_W-1:0]  unsaved_reg;
    logic [sfdl_pkg::BITPOS_W-1:0] supply_bit_reg;

    // block state
    logic [sfdl_pkg::FAULT_W-1:0]  active_reg,     active_next;
    logic [sfdl_pkg::FAULT_W-1:0]  saved_reg,      saved_next;
    logic                          deviating_reg,  deviating_next;
    logic                          dev_high_reg,   dev_high_next;
    logic [sfdl_pkg::DEB_W-1:0]    debounce_reg,   debounce_next;
    logic [sfdl_pkg::TICK_W-1:0]   lamp_cnt_reg,   lamp_cnt_next;
    logic                          lamp_reg,       lamp_next;
    logic [sfdl_pkg::STROKE_W-1:0] stroke_reg,     stroke_next;
    logic                          save_next;

    // output and skid
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    result_t res_next;

    logic in_accept;
    logic out_free;
    logic [sfdl_pkg::FAULT_W-1:0] supply_mask;
    logic [sfdl_pkg::FAULT_W-1:0] af;
    logic [sfdl_pkg::FAULT_W-1:0] merged;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_min_reg   <= sfdl_pkg::SUPPLY_MIN_RST;
            supply_max_reg   <= sfdl_pkg::SUPPLY_MAX_RST;
            supply_floor_reg <= sfdl_pkg::SUPPLY_FLOOR_RST;
            rpm_thresh_reg   <= sfdl_pkg::RPM_THRESH_RST;
            lamp_hold_reg    <= sfdl_pkg::LAMP_HOLD_RST;
            low_prio_reg     <= sfdl_pkg::LOW_PRIO_RST;
            unsaved_reg      <= sfdl_pkg::UNSAVED_RST;
            supply_bit_reg   <= sfdl_pkg::SUPPLY_BIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sfdl_pkg::REG_SUPPLY_MIN:   supply_min_reg   <= cfg_data[sfdl_pkg::VOLT_W-1:0];
                sfdl_pkg::REG_SUPPLY_MAX:   supply_max_reg   <= cfg_data[sfdl_pkg::VOLT_W-1:0];
                sfdl_pkg::REG_SUPPLY_FLOOR: supply_floor_reg <= cfg_data[sfdl_pkg::VOLT_W-1:0];
                sfdl_pkg::REG_RPM_THRESH:   rpm_thresh_reg   <= cfg_data[sfdl_pkg::RPM_W-1:0];
                sfdl_pkg::REG_LAMP_HOLD:    lamp_hold_reg    <= cfg_data[sfdl_pkg::TICK_W-1:0];
                sfdl_pkg::REG_LOW_PRIO:     low_prio_reg     <= cfg_data[sfdl_pkg::FAULT_W-1:0];
                sfdl_pkg::REG_UNSAVED:      unsaved_reg      <= cfg_data[sfdl_pkg::FAULT_W-1:0];
                sfdl_pkg::REG_SUPPLY_BIT:   supply_bit_reg   <= cfg_data[sfdl_pkg::BITPOS_W-1:0];
                default: ;
            endcase
        end
    end

    assign supply_mask = sfdl_pkg::FAULT_W'(1) << supply_bit_reg;

    always_comb
    begin
        active_next    = active_reg;
        saved_next     = saved_reg;
        deviating_next = deviating_reg;
        dev_high_next  = dev_high_reg;
        debounce_next  = debounce_reg;
        lamp_cnt_next  = lamp_cnt_reg;
        lamp_next      = lamp_reg;
        stroke_next    = stroke_reg;
        save_next      = 1'b0;
        af             = '0;
        merged         = '0;

        unique case (action)
            sfdl_pkg::ACT_CHECK:
            begin
                af = ((active_reg & ~fault_clear) | fault_set) & VEC_MASK;
                if (!deviating_reg)
                begin
                    if (supply_voltage < supply_min_reg)
                    begin
                        dev_high_next  = 1'b0;
                        deviating_next = 1'b1;
                    end
                    else if (supply_voltage > supply_max_reg)
                    begin
                        dev_high_next  = 1'b1;
                        deviating_next = 1'b1;
                    end
                    else
                    begin
                        af = af & ~supply_mask;
                    end
                    debounce_next = DEB_LOAD;
                end
                else if (debounce_reg != '0)
                begin
                    if ((!dev_high_reg && supply_voltage > supply_min_reg) ||
                        (dev_high_reg && supply_voltage < supply_max_reg))
                    begin
                        deviating_next = 1'b0;
                    end
                    debounce_next = debounce_reg - sfdl_pkg::DEB_W'(1);
                end
                else
                begin
                    if (supply_voltage > supply_floor_reg && engine_rpm > rpm_thresh_reg)
                    begin
                        af = af | supply_mask;
                    end
                    else
                    begin
                        af = af & ~supply_mask;
                    end
                    deviating_next = 1'b0;
                end
                af          = af & VEC_MASK;
                active_next = af;
                if (lamp_cnt_reg == '0)
                begin
                    lamp_next = 1'b0;
                end
                if (af != '0)
                begin
                    lamp_cnt_next = lamp_hold_reg;
                    lamp_next     = 1'b1;
                end
                merged     = (saved_reg | (af & ~unsaved_reg)) & VEC_MASK;
                save_next  = (merged != saved_reg);
                saved_next = merged;
            end
            sfdl_pkg::ACT_TICK:
            begin
                if (lamp_cnt_reg != '0)
                begin
                    lamp_cnt_next = lamp_cnt_reg - sfdl_pkg::TICK_W'(1);
                end
            end
            sfdl_pkg::ACT_STROKE:
            begin
                if (stroke_reg == sfdl_pkg::LOW_PRIO_STROKE)
                begin
                    active_next = active_reg & ~low_prio_reg;
                end
                if (stroke_reg != sfdl_pkg::STROKE_MAX)
                begin
                    stroke_next = stroke_reg + sfdl_pkg::STROKE_W'(1);
                end
            end
            sfdl_pkg::ACT_CLEAR:
            begin
                active_next    = '0;
                saved_next     = '0;
                deviating_next = 1'b0;
                dev_high_next  = 1'b0;
                debounce_next  = '0;
                stroke_next    = '0;
            end
            default: ;
        endcase

        res_next.faults = active_next;
        res_next.merged = saved_next;
        res_next.lamp   = lamp_next;
        res_next.save   = save_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            saved_reg     <= '0;
            deviating_reg <= 1'b0;
            dev_high_reg  <= 1'b0;
            debounce_reg  <= '0;
            lamp_cnt_reg  <= sfdl_pkg::LAMP_HOLD_RST;
            lamp_reg      <= 1'b1;
            stroke_reg    <= '0;
        end
        else if (in_accept)
        begin
            active_reg    <= active_next;
            saved_reg     <= saved_next;
            deviating_reg <= deviating_next;
            dev_high_reg  <= dev_high_next;
            debounce_reg  <= debounce_next;
            lamp_cnt_reg  <= lamp_cnt_next;
            lamp_reg      <= lamp_next;
            stroke_reg    <= stroke_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_accept)
            begin
                out_data_reg <= res_next;
            end
        end
        else if (in_accept)
        begin
            skid_data_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fault_vector  = out_data_reg.faults;
    assign merged_faults = out_data_reg.merged;
    assign lamp_lit      = out_data_reg.lamp;
    assign save_request  = out_data_reg.save;

endmodule

@@ rtl/sfdl_checker.sv @@
// ----------------------------------------------------------------------------
// sfdl_checker
// Port-level checks for the supply fault debounce and warning lamp block.
// ----------------------------------------------------------------------------
module sfdl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [sfdl_pkg::FAULT_W-1:0]   fault_vector,
    input logic [sfdl_pkg::FAULT_W-1:0]   merged_faults,
    input logic                           lamp_lit,
    input logic                           save_request
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fault_vector) &&
        $stable(merged_faults) && $stable(lamp_lit) && $stable(save_request))
        else $error("stalled result changed");

    // input backs up only behind a pending result
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall without pending result");

    // any active fault keeps the lamp on
    a_lamp_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (fault_vector != '0) |-> lamp_lit)
        else $error("fault present with lamp off");

    // a save request means the record holds something
    a_save_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && save_request |-> merged_faults != '0)
        else $error("save request with empty record");

endmodule

bind supply_fault_debounce_and_warning_lamp sfdl_checker u_sfdl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fault_vector  (fault_vector),
    .merged_faults (merged_faults),
    .lamp_lit      (lamp_lit),
    .save_request  (save_request)
);
